// ===== design/iarf_pkg.sv =====
// ----------------------------------------------------------------------------
// iarf_pkg: integer ALU register file package
// Widths, operation and status codes, and sequencer states shared by the
// interfaces and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package iarf_pkg;

	localparam int REGISTERS_DEF = 16;
	localparam int WORD_W        = 64;
	localparam int IDX_W         = 4;
	localparam int OP_W          = 4;
	localparam int STATUS_W      = 2;
	localparam int CNT_W         = $clog2(WORD_W);
	localparam int SH_W          = $clog2(WORD_W);

	localparam logic ACT_EXEC = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
	localparam logic [OP_W-1:0] OP_MOD  = 4'd4;
	localparam logic [OP_W-1:0] OP_AND  = 4'd5;
	localparam logic [OP_W-1:0] OP_OR   = 4'd6;
	localparam logic [OP_W-1:0] OP_XOR  = 4'd7;
	localparam logic [OP_W-1:0] OP_SHL  = 4'd8;
	localparam logic [OP_W-1:0] OP_SHR  = 4'd9;
	localparam logic [OP_W-1:0] OP_ROTL = 4'd10;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNSUP = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_OPER = 4'b0010,
		S_ITER = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ===== design/iarf_if.sv =====
// ----------------------------------------------------------------------------
// iarf_if: request and response channels
// Valid/ready channels carrying one instruction beat and one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface iarf_req_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [iarf_pkg::OP_W-1:0]     operation;
	logic [iarf_pkg::IDX_W-1:0]    first_index;
	logic [iarf_pkg::IDX_W-1:0]    second_index;
	logic [iarf_pkg::WORD_W-1:0]   load_value;

	modport source (output valid, action, operation, first_index, second_index,
		load_value, input ready);
	modport sink (input valid, action, operation, first_index, second_index,
		load_value, output ready);
endinterface

interface iarf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [iarf_pkg::WORD_W-1:0]   result_value;
	logic                          zero_flag;
	logic                          sign_flag;
	logic [iarf_pkg::STATUS_W-1:0] status;

	modport source (output valid, result_value, zero_flag, sign_flag, status,
		input ready);
	modport sink (input valid, result_value, zero_flag, sign_flag, status,
		output ready);
endinterface

`default_nettype wire

// ===== design/integer_alu_register_file.sv =====
// ----------------------------------------------------------------------------
// integer_alu_register_file: integer ALU on a 64-bit register file
// Two-register instructions and register loads; one shared 66-bit adder
// serves add, subtract, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
//  channel | modport | beat
//  req     | sink    | action, operation, first_index, second_index, load_value
//  rsp     | source  | result_value, zero_flag, sign_flag, status
//
//  Load, error:            operand state, then finish state, to registered result.
//  Add, sub, logic, shift: operand, iteration and finish states.
//  Mul, div, mod:          operand, 64 passes through the shared adder, finish.
//  One beat at a time; ready returns as the result registers,
//  even while it waits on rsp. A second result holds until rsp takes the first.
//  Reset clears the file through per-register valid bits, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_alu_register_file #(
	parameter int REGISTERS = iarf_pkg::REGISTERS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	iarf_req_if.sink   req,
	iarf_rsp_if.source rsp
);

	localparam int W  = iarf_pkg::WORD_W;
	localparam int AW = (REGISTERS > 1) ? $clog2(REGISTERS) : 1;
	localparam int EW = AW + iarf_pkg::IDX_W;
	localparam logic [iarf_pkg::CNT_W-1:0] CNT_LAST = iarf_pkg::CNT_W'(W - 1);

	iarf_pkg::state_t state_q;

	logic [W-1:0]           mem [REGISTERS];
	logic [REGISTERS-1:0]   valid_q;

	logic [EW-1:0]          ext_a, ext_b;
	logic [AW-1:0]          addr_a, addr_b;
	logic                   rng_a, rng_b;

	logic [W-1:0]           rd_a_q, rd_b_q;
	logic                   use_a_q, use_b_q;
	logic                   act_q;
	logic [iarf_pkg::OP_W-1:0] op_q;
	logic [AW-1:0]          wa_q;
	logic                   rng_wa_q;
	logic [W-1:0]           ld_q;

	logic [W-1:0]           a_q, b_q, acc_q, res_q;
	logic [iarf_pkg::CNT_W-1:0] cnt_q;
	logic [iarf_pkg::STATUS_W-1:0] status_q;
	logic                   wr_q, upd_q;
	logic [1:0]             flags_q;

	logic                   ovalid_q;
	logic [W-1:0]           ores_q;
	logic [1:0]             oflags_q;
	logic [iarf_pkg::STATUS_W-1:0] ostatus_q;

	logic [W-1:0]           opa, opb;
	logic [W+1:0]           add_x, add_y, sum;
	logic                   add_sub;
	logic [iarf_pkg::SH_W-1:0] sh;
	logic [2*W-1:0]         rot;
	logic [W-1:0]           step_res;
	logic                   ge;
	logic [W-1:0]           rem_n, quo_n;
	logic                   go;
	logic [1:0]             flags_n;
	logic                   accept;

	assign ext_a  = EW'(req.first_index);
	assign ext_b  = EW'(req.second_index);
	assign addr_a = ext_a[AW-1:0];
	assign addr_b = ext_b[AW-1:0];
	assign rng_a  = ext_a < EW'(REGISTERS);
	assign rng_b  = ext_b < EW'(REGISTERS);

	assign req.ready = (state_q == iarf_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;

	assign opa = use_a_q ? rd_a_q : '0;
	assign opb = use_b_q ? rd_b_q : '0;

	// shared adder
	always_comb begin
		add_x   = {2'b00, a_q};
		add_y   = {2'b00, b_q};
		add_sub = 1'b0;
		case (op_q)
			iarf_pkg::OP_SUB: begin
				add_sub = 1'b1;
			end
			iarf_pkg::OP_MUL: begin
				add_x = {2'b00, acc_q};
				add_y = {2'b00, a_q};
			end
			iarf_pkg::OP_DIV, iarf_pkg::OP_MOD: begin
				add_x   = {1'b0, acc_q, a_q[W-1]};
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign sum   = add_x + (add_y ^ {(W+2){add_sub}}) + (W+2)'(add_sub);
	assign ge    = !sum[W+1];
	assign rem_n = ge ? sum[W-1:0] : {acc_q[W-2:0], a_q[W-1]};
	assign quo_n = {a_q[W-2:0], ge};

	assign sh  = b_q[iarf_pkg::SH_W-1:0];
	assign rot = {a_q, a_q} << sh;

	always_comb begin
		case (op_q)
			iarf_pkg::OP_ADD, iarf_pkg::OP_SUB: step_res = sum[W-1:0];
			iarf_pkg::OP_AND:  step_res = a_q & b_q;
			iarf_pkg::OP_OR:   step_res = a_q | b_q;
			iarf_pkg::OP_XOR:  step_res = a_q ^ b_q;
			iarf_pkg::OP_SHL:  step_res = a_q << sh;
			iarf_pkg::OP_SHR:  step_res = a_q >> sh;
			iarf_pkg::OP_ROTL: step_res = rot[2*W-1:W];
			default:           step_res = '0;
		endcase
	end

	assign go      = (state_q == iarf_pkg::S_FIN) && (!ovalid_q || rsp.ready);
	assign flags_n = upd_q ? {res_q[W-1], (res_q == '0)} : flags_q;

	// register file, read ports registered
	always_ff @(posedge clk) begin
		if (go && wr_q) begin
			mem[wa_q] <= res_q;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= iarf_pkg::S_IDLE;
			valid_q  <= '0;
			flags_q  <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
			use_a_q  <= 1'b0;
			use_b_q  <= 1'b0;
		end else begin
			use_a_q <= rng_a && valid_q[addr_a];
			use_b_q <= rng_b && valid_q[addr_b];
			if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				iarf_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= iarf_pkg::S_OPER;
					end
				end
				iarf_pkg::S_OPER: begin
					cnt_q <= '0;
					if (act_q == iarf_pkg::ACT_LOAD || op_q > iarf_pkg::OP_ROTL ||
						((op_q == iarf_pkg::OP_DIV || op_q == iarf_pkg::OP_MOD) &&
						opb == '0)) begin
						state_q <= iarf_pkg::S_FIN;
					end else begin
						state_q <= iarf_pkg::S_ITER;
					end
				end
				iarf_pkg::S_ITER: begin
					if (op_q == iarf_pkg::OP_MUL || op_q == iarf_pkg::OP_DIV ||
						op_q == iarf_pkg::OP_MOD) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_LAST) begin
							state_q <= iarf_pkg::S_FIN;
						end
					end else begin
						state_q <= iarf_pkg::S_FIN;
					end
				end
				iarf_pkg::S_FIN: begin
					if (go) begin
						ovalid_q <= 1'b1;
						flags_q  <= flags_n;
						if (wr_q) begin
							valid_q[wa_q] <= 1'b1;
						end
						state_q <= iarf_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= iarf_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= req.action;
			op_q     <= req.operation;
			wa_q     <= addr_a;
			rng_wa_q <= rng_a;
			ld_q     <= req.load_value;
		end
		case (state_q)
			iarf_pkg::S_OPER: begin
				a_q      <= opa;
				b_q      <= opb;
				acc_q    <= '0;
				res_q    <= '0;
				status_q <= iarf_pkg::ST_OK;
				wr_q     <= rng_wa_q;
				upd_q    <= 1'b1;
				if (act_q == iarf_pkg::ACT_LOAD) begin
					res_q <= ld_q;
					upd_q <= 1'b0;
				end else if (op_q > iarf_pkg::OP_ROTL) begin
					status_q <= iarf_pkg::ST_UNSUP;
					wr_q     <= 1'b0;
					upd_q    <= 1'b0;
				end else if ((op_q == iarf_pkg::OP_DIV || op_q == iarf_pkg::OP_MOD) &&
					opb == '0) begin
					status_q <= iarf_pkg::ST_DIVZ;
					wr_q     <= 1'b0;
					upd_q    <= 1'b0;
				end
			end
			iarf_pkg::S_ITER: begin
				case (op_q)
					iarf_pkg::OP_MUL: begin
						if (b_q[0]) begin
							acc_q <= sum[W-1:0];
						end
						a_q   <= a_q << 1;
						b_q   <= b_q >> 1;
						res_q <= b_q[0] ? sum[W-1:0] : acc_q;
					end
					iarf_pkg::OP_DIV, iarf_pkg::OP_MOD: begin
						acc_q <= rem_n;
						a_q   <= quo_n;
						res_q <= (op_q == iarf_pkg::OP_DIV) ? quo_n : rem_n;
					end
					default: begin
						res_q <= step_res;
					end
				endcase
			end
			default: begin
			end
		endcase
		if (go) begin
			ores_q    <= res_q;
			oflags_q  <= flags_n;
			ostatus_q <= status_q;
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.result_value = ores_q;
	assign rsp.zero_flag    = oflags_q[0];
	assign rsp.sign_flag    = oflags_q[1];
	assign rsp.status       = ostatus_q;

	// checks
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != iarf_pkg::S_ITER) |-> (cnt_q == '0))
		else $error("iteration count left non-zero outside iteration");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(flags_q))
		else $error("flags changed without a finished instruction");

	a_err_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == iarf_pkg::S_FIN) && (status_q != iarf_pkg::ST_OK)) |->
		(!wr_q && !upd_q))
		else $error("error result would change state");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == iarf_pkg::S_FIN))
		else $error("response raised outside the finish step");

endmodule

`default_nettype wire
